// ===== hw/rtl/sti_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the scaled table interpolator.
// No dependencies; imported by every module of the block.
package sti_pkg;

   localparam int WORD_W     = 32;
   localparam int COUNT_W    = 9;
   localparam int INDEX_W    = 8;
   localparam int CSR_ADDR_W = 2;
   // widest table address over the supported table depths
   localparam int ADDR_W_MAX = 12;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [CSR_ADDR_W-1:0] CSR_SCALE  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_OFFSET = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_COUNT  = 2'd2;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 9'd256;

   localparam logic REQ_LOOKUP = 1'b0;
   localparam logic REQ_WRITE  = 1'b1;

   typedef enum logic [1:0] {
      OP_WRITE,
      OP_CLAMP,
      OP_INTERP
   } sti_op_type;

   typedef struct packed {
      sti_op_type              op;
      logic                    eov;
      logic [ADDR_W_MAX-1:0]   addr;
      logic [WORD_W-1:0]       data;
   } sti_entry_type;

endpackage

// ===== hw/rtl/scaled_table_interpolate_top.sv =====
`timescale 1ns / 1ps
// Scaled table interpolator: control registers plus front end, queue and back end.
// Depends on sti_pkg, sti_front, sti_queue and sti_back.
//
// Accepts one beat per cycle while the queue has room, lookups and table writes
// alike, in order. A lookup maps its sample to p = sample*scale + offset and returns
// the clamped or linearly interpolated table value; a table write returns nothing.
// Sustained rate is one beat per clock while responses are taken, set by the single
// table memory with one write and two read ports. A lookup passes through the front
// end (position multiply, offset add), the queue and the back end (memory read,
// difference, interpolation multiply, output register). Write the control registers
// only while no lookup is in flight.
module scaled_table_interpolate_top import sti_pkg::*; #(
   parameter int TABLE_DEPTH = 256,
   parameter int FRAC_BITS   = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_we,
   input  logic [CSR_ADDR_W-1:0]     csr_index,
   input  logic [WORD_W-1:0]         csr_wdata,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_type,
   input  logic signed [WORD_W-1:0]  req_sample,
   input  logic [INDEX_W-1:0]        req_entry_index,
   input  logic signed [WORD_W-1:0]  req_entry_value,
   input  logic                      req_end_of_vector,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [WORD_W-1:0]  rsp_result,
   output logic                      rsp_end_of_vector_out
);

   localparam logic [WORD_W-1:0] SCALE_ONE = WORD_W'(1) << FRAC_BITS;

   logic signed [WORD_W-1:0]  scale_ff;
   logic signed [WORD_W-1:0]  offset_ff;
   logic [COUNT_W-1:0]        count_ff;
   logic                      push;
   logic                      full;
   logic                      pop;
   logic                      empty;
   sti_entry_type             push_entry;
   sti_entry_type             pop_entry;

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff  <= SCALE_ONE;
         offset_ff <= '0;
         count_ff  <= COUNT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SCALE:  scale_ff  <= csr_wdata;
            CSR_OFFSET: offset_ff <= csr_wdata;
            CSR_COUNT:  count_ff  <= csr_wdata[COUNT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   sti_front #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_sample        (req_sample),
      .req_entry_index   (req_entry_index),
      .req_entry_value   (req_entry_value),
      .req_end_of_vector (req_end_of_vector),
      .scale             (scale_ff),
      .offset            (offset_ff),
      .table_count       (count_ff),
      .push              (push),
      .push_entry        (push_entry),
      .full              (full)
   );

   sti_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .empty      (empty)
   );

   sti_back #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .FRAC_BITS   (FRAC_BITS)
   ) u_back (
      .clock                 (clock),
      .reset                 (reset),
      .pop                   (pop),
      .pop_entry             (pop_entry),
      .empty                 (empty),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_result            (rsp_result),
      .rsp_end_of_vector_out (rsp_end_of_vector_out)
   );

endmodule

// ===== hw/rtl/sti_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts request beats, forms the table position and classifies it.
// Depends on sti_pkg; feeds sti_queue.
module sti_front import sti_pkg::*; #(
   parameter int TABLE_DEPTH = 256,
   parameter int FRAC_BITS   = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_type,
   input  logic signed [WORD_W-1:0]  req_sample,
   input  logic [INDEX_W-1:0]        req_entry_index,
   input  logic signed [WORD_W-1:0]  req_entry_value,
   input  logic                      req_end_of_vector,
   input  logic signed [WORD_W-1:0]  scale,
   input  logic signed [WORD_W-1:0]  offset,
   input  logic [COUNT_W-1:0]        table_count,
   output logic                      push,
   output sti_entry_type             push_entry,
   input  logic                      full
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int XW = 64 - 2 * FRAC_BITS;

   logic                     advance;
   logic                     f1_valid_ff;
   logic                     f1_type_ff;
   logic                     f1_eov_ff;
   logic [INDEX_W-1:0]       f1_idx_ff;
   logic [WORD_W-1:0]        f1_val_ff;
   logic signed [63:0]       f1_prod_ff;
   logic signed [63:0]       f1_prod_in;
   logic                     f2_valid_ff;
   logic                     f2_type_ff;
   logic                     f2_eov_ff;
   logic [INDEX_W-1:0]       f2_idx_ff;
   logic [WORD_W-1:0]        f2_val_ff;
   logic signed [63:0]       f2_pos_ff;
   logic signed [63:0]       f2_pos_in;
   logic signed [63:0]       offset_ext;
   logic [AW-1:0]            last;
   logic [XW-1:0]            pos_int;
   logic [FRAC_BITS-1:0]     pos_frac;
   logic                     keep;

   assign advance    = !f2_valid_ff || !full;
   assign req_ready  = advance;
   assign f1_prod_in = req_sample * scale;
   assign offset_ext = {{32{offset[WORD_W-1]}}, offset} <<< FRAC_BITS;
   assign f2_pos_in  = f1_prod_ff + offset_ext;

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_valid_ff <= 1'b0;
         f2_valid_ff <= 1'b0;
      end else if (advance) begin
         f1_valid_ff <= req_valid;
         f2_valid_ff <= f1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         f1_type_ff <= req_type;
         f1_eov_ff  <= req_end_of_vector;
         f1_idx_ff  <= req_entry_index;
         f1_val_ff  <= req_entry_value;
         f1_prod_ff <= f1_prod_in;
         f2_type_ff <= f1_type_ff;
         f2_eov_ff  <= f1_eov_ff;
         f2_idx_ff  <= f1_idx_ff;
         f2_val_ff  <= f1_val_ff;
         f2_pos_ff  <= f2_pos_in;
      end
   end

   always_comb begin
      if (table_count == '0) begin
         last = '0;
      end else if (int'(table_count) > TABLE_DEPTH) begin
         last = AW'(TABLE_DEPTH - 1);
      end else begin
         last = AW'(int'(table_count) - 1);
      end
   end

   assign pos_int  = f2_pos_ff[63:2*FRAC_BITS];
   assign pos_frac = f2_pos_ff[2*FRAC_BITS-1:FRAC_BITS];

   always_comb begin
      push_entry.eov = f2_eov_ff;
      keep           = 1'b1;
      if (f2_type_ff == REQ_WRITE) begin
         push_entry.op   = OP_WRITE;
         push_entry.addr = ADDR_W_MAX'(f2_idx_ff);
         push_entry.data = f2_val_ff;
         keep            = int'(f2_idx_ff) < TABLE_DEPTH;
      end else if (f2_pos_ff[63] || f2_pos_ff == '0) begin
         push_entry.op   = OP_CLAMP;
         push_entry.addr = '0;
         push_entry.data = '0;
      end else if (pos_int >= XW'(last)) begin
         push_entry.op   = OP_CLAMP;
         push_entry.addr = ADDR_W_MAX'(last);
         push_entry.data = '0;
      end else begin
         push_entry.op   = OP_INTERP;
         push_entry.addr = ADDR_W_MAX'(pos_int[AW-1:0]);
         push_entry.data = WORD_W'(pos_frac);
      end
   end

   assign push = f2_valid_ff && !full && keep;

endmodule

// ===== hw/rtl/sti_queue.sv =====
`timescale 1ns / 1ps
// Short FIFO of classified beats between front end and back end.
// Depends on sti_pkg.
module sti_queue import sti_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  sti_entry_type  push_entry,
   output logic           full,
   input  logic           pop,
   output sti_entry_type  pop_entry,
   output logic           empty
);

   localparam int PW = $clog2(QUEUE_DEPTH);

   sti_entry_type   q_ff [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ptr_ff;
   logic [PW-1:0]   rd_ptr_ff;
   logic [PW:0]     count_ff;
   logic [PW:0]     count_in;

   assign full      = count_ff == (PW+1)'(QUEUE_DEPTH);
   assign empty     = count_ff == '0;
   assign pop_entry = q_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== hw/rtl/sti_back.sv =====
`timescale 1ns / 1ps
// Back end: table memory, neighbor reads, interpolation and response register.
// Depends on sti_pkg; drains sti_queue.
module sti_back import sti_pkg::*; #(
   parameter int TABLE_DEPTH = 256,
   parameter int FRAC_BITS   = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   output logic                      pop,
   input  sti_entry_type             pop_entry,
   input  logic                      empty,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic signed [WORD_W-1:0]  rsp_result,
   output logic                      rsp_end_of_vector_out
);

   localparam int AW    = $clog2(TABLE_DEPTH);
   localparam int PRODW = WORD_W + 2 + FRAC_BITS;

   logic [WORD_W-1:0]          mem [TABLE_DEPTH];
   logic                       advance;
   logic [AW-1:0]              addr0;
   logic [AW-1:0]              addr1;
   logic [WORD_W-1:0]          rd0_ff;
   logic [WORD_W-1:0]          rd1_ff;
   logic                       b1_valid_ff;
   logic                       b1_clamp_ff;
   logic [FRAC_BITS-1:0]       b1_frac_ff;
   logic                       b1_eov_ff;
   logic                       b2_valid_ff;
   logic                       b2_clamp_ff;
   logic [FRAC_BITS-1:0]       b2_frac_ff;
   logic                       b2_eov_ff;
   logic signed [WORD_W-1:0]   b2_e0_ff;
   logic signed [WORD_W:0]     b2_diff_ff;
   logic signed [WORD_W:0]     b2_diff_in;
   logic                       b3_valid_ff;
   logic                       b3_clamp_ff;
   logic                       b3_eov_ff;
   logic signed [WORD_W-1:0]   b3_e0_ff;
   logic signed [PRODW-1:0]    b3_prod_ff;
   logic signed [PRODW-1:0]    b3_prod_in;
   logic                       rsp_valid_ff;
   logic signed [WORD_W-1:0]   rsp_result_ff;
   logic signed [WORD_W-1:0]   rsp_result_in;
   logic                       rsp_eov_ff;

   assign advance = !rsp_valid_ff || rsp_ready;
   assign pop     = advance && !empty;
   assign addr0   = pop_entry.addr[AW-1:0];
   assign addr1   = addr0 + AW'(1);

   always_ff @(posedge clock) begin
      if (pop) begin
         if (pop_entry.op == OP_WRITE) begin
            mem[addr0] <= pop_entry.data;
         end
         rd0_ff <= mem[addr0];
         rd1_ff <= mem[addr1];
      end
   end

   assign b2_diff_in    = $signed({rd1_ff[WORD_W-1], rd1_ff}) -
                          $signed({rd0_ff[WORD_W-1], rd0_ff});
   assign b3_prod_in    = b2_diff_ff * $signed({1'b0, b2_frac_ff});
   assign rsp_result_in = b3_clamp_ff ? b3_e0_ff : b3_e0_ff + b3_prod_ff[FRAC_BITS +: WORD_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         b1_valid_ff  <= 1'b0;
         b2_valid_ff  <= 1'b0;
         b3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         b1_valid_ff  <= pop && pop_entry.op != OP_WRITE;
         b2_valid_ff  <= b1_valid_ff;
         b3_valid_ff  <= b2_valid_ff;
         rsp_valid_ff <= b3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         b1_clamp_ff <= pop_entry.op == OP_CLAMP;
         b1_frac_ff  <= pop_entry.data[FRAC_BITS-1:0];
         b1_eov_ff   <= pop_entry.eov;
      end
      if (advance) begin
         b2_clamp_ff   <= b1_clamp_ff;
         b2_frac_ff    <= b1_frac_ff;
         b2_eov_ff     <= b1_eov_ff;
         b2_e0_ff      <= rd0_ff;
         b2_diff_ff    <= b2_diff_in;
         b3_clamp_ff   <= b2_clamp_ff;
         b3_eov_ff     <= b2_eov_ff;
         b3_e0_ff      <= b2_e0_ff;
         b3_prod_ff    <= b3_prod_in;
         rsp_result_ff <= rsp_result_in;
         rsp_eov_ff    <= b3_eov_ff;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_result            = rsp_result_ff;
   assign rsp_end_of_vector_out = rsp_eov_ff;

endmodule

// ===== verif/tb_top.sv =====
`timescale 1ns / 1ps
// Testbench for scaled_table_interpolate_top: table writes and lookups over a set of register
// settings, with an in-bench interpolation model that checks every response beat in order.
// Depends on sti_pkg and the scaled table interpolator RTL; needs no files or arguments.
module tb_top;
   import sti_pkg::*;

   localparam int TABLE_DEPTH  = 256;
   localparam int FRAC_BITS    = 16;
   localparam int STALL_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 12;
   localparam int PHASE_ITEMS  = 130;
   localparam int NUM_PHASES   = 11;

   typedef struct {
      logic                     kind;
      logic signed [WORD_W-1:0] sample;
      logic [INDEX_W-1:0]       index;
      logic signed [WORD_W-1:0] value;
      logic                     eov;
   } req_beat_type;

   typedef struct {
      logic signed [WORD_W-1:0] result;
      logic                     eov;
   } interp_beat_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     csr_we = 1'b0;
   logic [CSR_ADDR_W-1:0]    csr_index = CSR_SCALE;
   logic [WORD_W-1:0]        csr_wdata = '0;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic                     req_type = REQ_LOOKUP;
   logic signed [WORD_W-1:0] req_sample = '0;
   logic [INDEX_W-1:0]       req_entry_index = '0;
   logic signed [WORD_W-1:0] req_entry_value = '0;
   logic                     req_end_of_vector = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic signed [WORD_W-1:0] rsp_result;
   logic                     rsp_end_of_vector_out;

   // model state
   logic signed [WORD_W-1:0] cfg_scale = 32'sh00010000;
   logic signed [WORD_W-1:0] cfg_offset = '0;
   logic [COUNT_W-1:0]       cfg_count = COUNT_RESET;
   logic signed [WORD_W-1:0] entry_model [TABLE_DEPTH];
   bit                       gen_written [TABLE_DEPTH];

   req_beat_type    req_queue [$];
   req_beat_type    next_beat;
   interp_beat_type expected_interp [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int mismatches = 0;
   int n_checked = 0;
   int n_writes = 0;
   int stall_cycles = 0;

   scaled_table_interpolate_top #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .FRAC_BITS  (FRAC_BITS)
   ) i_dut (
      .clock                (clock),
      .reset                (reset),
      .csr_we               (csr_we),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_type             (req_type),
      .req_sample           (req_sample),
      .req_entry_index      (req_entry_index),
      .req_entry_value      (req_entry_value),
      .req_end_of_vector    (req_end_of_vector),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_result           (rsp_result),
      .rsp_end_of_vector_out(rsp_end_of_vector_out)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic int unsigned last_entry();
      int unsigned n;
      n = (cfg_count == 0) ? 1 : int'(cfg_count);
      if (n > TABLE_DEPTH) n = TABLE_DEPTH;
      return n - 1;
   endfunction

   function automatic void locate_position(input logic signed [WORD_W-1:0] smp,
                                           output int unsigned base,
                                           output logic [FRAC_BITS-1:0] weight,
                                           output bit blend);
      longint pos;
      longint whole;
      pos = longint'(smp) * longint'(cfg_scale) + (longint'(cfg_offset) <<< FRAC_BITS);
      base = 0;
      weight = '0;
      blend = 1'b0;
      if (pos > 0) begin
         whole = pos >>> (2 * FRAC_BITS);
         if (whole >= longint'(last_entry())) begin
            base = last_entry();
         end else begin
            base = 32'(whole);
            weight = pos[2*FRAC_BITS-1:FRAC_BITS];
            blend = 1'b1;
         end
      end
   endfunction

   function automatic logic signed [WORD_W-1:0] interp_lookup(
         input logic signed [WORD_W-1:0] smp);
      int unsigned base;
      logic [FRAC_BITS-1:0] weight;
      bit blend;
      longint delta;
      longint sum;
      locate_position(smp, base, weight, blend);
      if (!blend) return entry_model[base];
      delta = (longint'(entry_model[base + 1]) - longint'(entry_model[base])) * longint'(weight);
      sum = longint'(entry_model[base]) + (delta >>> FRAC_BITS);
      return sum[WORD_W-1:0];
   endfunction

   function automatic logic signed [WORD_W-1:0] random_entry_value();
      case ($urandom_range(9))
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         2: return 32'sh00000000;
         3: return int'($urandom_range(200000)) - 100000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic signed [WORD_W-1:0] random_sample();
      longint target;
      longint smp;
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 55) begin
         // aim at a table position, then solve for the sample
         target = (longint'($urandom_range(last_entry() + 1)) <<< (2 * FRAC_BITS))
                  + longint'($urandom);
         if (pick < 10) target = (target >>> (2 * FRAC_BITS)) <<< (2 * FRAC_BITS);
         if (cfg_scale == 0) return $urandom;
         smp = (target - (longint'(cfg_offset) <<< FRAC_BITS)) / longint'(cfg_scale);
         if (smp > 64'sd2147483647) smp = 64'sd2147483647;
         if (smp < -64'sd2147483648) smp = -64'sd2147483648;
         return smp[WORD_W-1:0];
      end
      if (pick < 70) begin
         case ($urandom_range(4))
            0: return 32'sh00000000;
            1: return 32'sh7FFFFFFF;
            2: return 32'sh80000000;
            3: return 32'shFFFFFFFF;
            default: return 32'sh00000001;
         endcase
      end
      return $urandom;
   endfunction

   function automatic void phase_setting(input int ph, output logic [WORD_W-1:0] scale_val,
                                         output logic [WORD_W-1:0] offset_val,
                                         output logic [WORD_W-1:0] count_val);
      case (ph)
         1:  begin scale_val = 32'h00010000; offset_val = 32'h00000000; count_val = 256; end
         2:  begin scale_val = 32'h00010000; offset_val = 32'h00000000; count_val = 16;  end
         3:  begin scale_val = 32'h00008000; offset_val = 32'h00030000; count_val = 64;  end
         4:  begin scale_val = 32'h7FFFFFFF; offset_val = 32'h7FFFFFFF; count_val = 256; end
         5:  begin scale_val = 32'h80000000; offset_val = 32'h80000000; count_val = 200; end
         6:  begin scale_val = 32'hFFFF0000; offset_val = 32'h00640000; count_val = 128; end
         7:  begin scale_val = 32'h00000000; offset_val = 32'h00058000; count_val = 8;   end
         8:  begin scale_val = 32'h00012345; offset_val = 32'hFFFE8000; count_val = 0;   end
         9:  begin scale_val = 32'h00020000; offset_val = 32'hFFFF0000; count_val = 511; end
         10: begin scale_val = 32'h00010000; offset_val = 32'h00000000; count_val = 2;   end
         default: begin scale_val = 32'h00000001; offset_val = 32'h00000000; count_val = 1; end
      endcase
   endfunction

   task automatic push_write(input logic [INDEX_W-1:0] idx, input logic signed [WORD_W-1:0] val);
      req_beat_type b;
      b.kind = REQ_WRITE;
      b.sample = $urandom;
      b.index = idx;
      b.value = val;
      b.eov = 1'($urandom_range(1));
      req_queue.push_back(b);
      gen_written[idx] = 1'b1;
   endtask

   task automatic push_lookup(input logic signed [WORD_W-1:0] smp, input logic eov);
      req_beat_type b;
      int unsigned base;
      logic [FRAC_BITS-1:0] weight;
      bit blend;
      locate_position(smp, base, weight, blend);
      // load any entry this lookup would read that holds nothing yet
      if (!gen_written[base]) push_write(INDEX_W'(base), random_entry_value());
      if (blend && !gen_written[base + 1]) push_write(INDEX_W'(base + 1), random_entry_value());
      b.kind = REQ_LOOKUP;
      b.sample = smp;
      b.index = INDEX_W'($urandom_range(255));
      b.value = $urandom;
      b.eov = eov;
      req_queue.push_back(b);
   endtask

   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input logic [WORD_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         CSR_SCALE:  cfg_scale = val;
         CSR_OFFSET: cfg_offset = val;
         CSR_COUNT:  cfg_count = val[COUNT_W-1:0];
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      do @(negedge clock); while (req_queue.size() != 0 || req_valid || expected_interp.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_idle(input int ph);
      if (ph <= 4) begin
         send_idle_pct = 31;
         recv_idle_pct = 62;
      end else if (ph <= 8) begin
         send_idle_pct = 62;
         recv_idle_pct = 31;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   endtask

   initial begin
      logic [WORD_W-1:0] s_val;
      logic [WORD_W-1:0] o_val;
      logic [WORD_W-1:0] c_val;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      set_idle(0);
      // full-range steps between neighbors, both clamps, exact boundaries
      push_write(0, 32'sh80000000);
      push_write(1, 32'sh7FFFFFFF);
      push_write(2, 32'sh80000000);
      push_write(3, 32'sh7FFFFFFF);
      push_write(254, 32'sh00000000);
      push_write(255, 32'sh12345678);
      push_lookup(32'sh00000000, 1'b0);
      push_lookup(32'sh80000000, 1'b1);
      push_lookup(32'shFFFFFFFF, 1'b0);
      push_lookup(32'sh7FFFFFFF, 1'b1);
      push_lookup(32'sh00FF0000, 1'b0);
      push_lookup(32'sh00FEFFFF, 1'b1);
      push_lookup(32'sh00018000, 1'b0);
      push_lookup(32'sh0002FFFF, 1'b1);
      push_lookup(32'sh00000001, 1'b0);
      push_lookup(32'sh00010000, 1'b1);
      push_lookup(32'sh00020000, 1'b0);
      for (int ph = 1; ph <= NUM_PHASES; ph++) begin
         wait_drained();
         phase_setting(ph, s_val, o_val, c_val);
         write_reg(CSR_SCALE, s_val);
         write_reg(CSR_OFFSET, o_val);
         write_reg(CSR_COUNT, c_val);
         @(posedge clock) csr_we <= 1'b0;
         @(negedge clock);
         set_idle(ph);
         repeat (PHASE_ITEMS) begin
            if ($urandom_range(99) < 20) begin
               push_write(INDEX_W'($urandom_range(255)), random_entry_value());
            end else begin
               push_lookup(random_sample(), 1'($urandom_range(1)));
            end
         end
      end
      wait_drained();
      $display("Checked %0d lookup beats against %0d table writes across %0d register settings,",
               n_checked, n_writes, NUM_PHASES + 1);
      $display("with sender and receiver stalls in both mixes and at full rate.");
      if (mismatches == 0 && expected_interp.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_beat = req_queue.pop_front();
            req_valid <= 1'b1;
            req_type <= next_beat.kind;
            req_sample <= next_beat.sample;
            req_entry_index <= next_beat.index;
            req_entry_value <= next_beat.value;
            req_end_of_vector <= next_beat.eov;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      rsp_ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      interp_beat_type fresh;
      interp_beat_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            if (req_type == REQ_WRITE) begin
               entry_model[req_entry_index] = req_entry_value;
               n_writes++;
            end else begin
               fresh.result = interp_lookup(req_sample);
               fresh.eov = req_end_of_vector;
               expected_interp.push_back(fresh);
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_interp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected response beat: result %h eov %b",
                           rsp_result, rsp_end_of_vector_out);
            end else begin
               want = expected_interp.pop_front();
               n_checked++;
               if (rsp_result !== want.result || rsp_end_of_vector_out !== want.eov) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: result exp %h got %h, eov exp %b got %b",
                              want.result, rsp_result, want.eov, rsp_end_of_vector_out);
               end
            end
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (req_queue.size() == 0 && !req_valid && expected_interp.size() == 0)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
         if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles, %0d responses outstanding",
                     STALL_LIMIT, expected_interp.size());
            $display("TEST FAILED");
            $finish;
         end
      end
   end

endmodule
